[rtl/bsa_pkg.sv]
// Shared types, codes and constants of the binding slot allocator.
package bsa_pkg;

    localparam int SLOTS_DEFAULT       = 32;
    localparam int MAP_ENTRIES_DEFAULT = 64;
    localparam int KINDS               = 5;
    localparam int KIND_W              = 3;
    localparam int IDENT_W             = 32;
    localparam int SLOT_FIELD_W        = 5;
    localparam int MASK_W              = 32;
    localparam int LIMIT_W             = 6;
    localparam int CFG_IDX_W           = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET_DEFAULT = 6'd16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET_ATOMIC  = 6'd0;

    // Opcodes.
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_RESET   = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_HELD    = 3'd1;
    localparam logic [2:0] ST_NONE    = 3'd2;
    localparam logic [2:0] ST_FREED   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;
    localparam logic [2:0] ST_RESET   = 3'd6;
    localparam logic [2:0] ST_QUERY   = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_STORAGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_UNIFORM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ARRAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ELEMENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ATOMIC  = 3'd4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [KIND_W-1:0]  buffer_kind;
        logic [IDENT_W-1:0] buffer_ident;
    } t_in;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        logic [2:0]              status;
        logic [MASK_W-1:0]       used_mask;
    } t_out;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic exec;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_sts;

endpackage

[rtl/bsa_ram.sv]
// Generic simple dual-port RAM with registered read data.
module bsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bsa_ctrl.sv]
// Controller state machine: accept, identifier scan, execute, result hand-off.
module bsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_opcode,
    input  logic          i_out_stall,
    input  bsa_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output bsa_pkg::t_cmd o_cmd
);
    import bsa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;
    logic       needs_scan;
    logic       out_free;

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign needs_scan = (i_opcode == OP_ALLOC) || (i_opcode == OP_RELEASE);
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = needs_scan ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.accept     = accept;
        o_cmd.scan_start = accept && needs_scan;
        o_cmd.exec       = (r_state == S_EXEC);
        o_cmd.out_load   = (r_state == S_RESP) && out_free;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[rtl/bsa_dp.sv]
// Datapath: limit registers, slot maps, identifier table scan and result register.
module bsa_dp #(
    parameter int SLOTS       = bsa_pkg::SLOTS_DEFAULT,
    parameter int MAP_ENTRIES = bsa_pkg::MAP_ENTRIES_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bsa_pkg::t_cmd                       i_cmd,
    output bsa_pkg::t_sts                       o_sts,
    input  bsa_pkg::t_in                        i_in_data,
    input  logic                                i_cfg_we,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bsa_pkg::LIMIT_W-1:0]         i_cfg_data,
    output bsa_pkg::t_out                       o_out_data
);
    import bsa_pkg::*;

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_W   = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int ENTRY_W = IDENT_W + SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAP_ENTRIES - 1);

    function automatic logic [SLOTS-1:0] f_seed(input logic [LIMIT_W-1:0] lim);
        logic [SLOTS-1:0] v;
        for (int i = 0; i < SLOTS; i++) begin
            v[i] = (LIMIT_W'(i) < lim);
        end
        return v;
    endfunction

    function automatic logic [SLOTS-1:0] f_onehot(input logic [SLOT_W-1:0] s);
        logic [SLOTS-1:0] v;
        for (int i = 0; i < SLOTS; i++) begin
            v[i] = (s == SLOT_W'(i));
        end
        return v;
    endfunction

    // Request registers.
    logic [1:0]           r_op;
    logic [KIND_W-1:0]    r_kind;
    logic [IDENT_W-1:0]   r_ident;

    logic [LIMIT_W-1:0]   r_limit [KINDS];
    logic [SLOTS-1:0]     r_free  [KINDS];
    logic [SLOTS-1:0]     n_free  [KINDS];
    logic [SLOTS-1:0]     r_used  [KINDS];
    logic [SLOTS-1:0]     n_used  [KINDS];
    logic [MAP_ENTRIES-1:0] r_valid;
    logic [MAP_ENTRIES-1:0] n_valid;

    // Scan pipeline: read issue stage and compare stage.
    logic [IDX_W-1:0]     r_rd_idx;
    logic                 r_rd_act;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_cmp_act;
    logic                 r_hit;
    logic [IDX_W-1:0]     r_hit_idx;
    logic [SLOT_W-1:0]    r_hit_slot;
    logic                 r_free_found;
    logic [IDX_W-1:0]     r_free_idx;

    logic [SLOT_W-1:0]    r_low_idx;
    logic                 r_low_nz;
    logic [SLOT_W-1:0]    n_low_idx;
    logic [SLOTS-1:0]     low_iso;

    logic [SLOT_W-1:0]    r_res_slot;
    logic [2:0]           r_res_status;
    logic [SLOT_W-1:0]    n_res_slot;
    logic [2:0]           n_res_status;
    t_out                 r_out;

    logic                 kind_ok;
    logic [SLOTS-1:0]     sel_free;
    logic [SLOTS-1:0]     sel_used;
    logic [MASK_W-1:0]    mask32;
    logic [SLOT_FIELD_W-1:0] slot5;

    logic                 ram_we;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [IDENT_W-1:0]   rd_ident;
    logic [SLOT_W-1:0]    rd_slot;
    logic                 cmp_hit;
    logic                 scan_done;

    bsa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAP_ENTRIES),
        .AW    (IDX_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_idx),
        .i_wdata ({r_ident, r_low_idx}),
        .i_re    (r_rd_act),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_ident  = ram_rdata[ENTRY_W-1:SLOT_W];
    assign rd_slot   = ram_rdata[SLOT_W-1:0];
    assign cmp_hit   = r_cmp_act && r_valid[r_cmp_idx] && (rd_ident == r_ident);
    assign scan_done = r_cmp_act && (cmp_hit || (r_cmp_idx == LAST_IDX));
    assign o_sts.scan_done = scan_done;

    assign kind_ok = (r_kind < KIND_W'(KINDS));

    always_comb begin
        sel_free = '0;
        sel_used = '0;
        for (int k = 0; k < KINDS; k++) begin
            if (r_kind == KIND_W'(k)) begin
                sel_free = r_free[k];
                sel_used = r_used[k];
            end
        end
    end

    // Lowest free slot: isolate the lowest set bit, then encode it.
    assign low_iso = sel_free & (~sel_free + SLOTS'(1));
    always_comb begin
        n_low_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (low_iso[i]) begin
                n_low_idx = n_low_idx | SLOT_W'(i);
            end
        end
    end

    generate
        if (SLOTS >= MASK_W) begin : g_mask_cut
            assign mask32 = sel_used[MASK_W-1:0];
        end else begin : g_mask_ext
            assign mask32 = {{(MASK_W - SLOTS){1'b0}}, sel_used};
        end
        if (SLOT_W >= SLOT_FIELD_W) begin : g_slot_cut
            assign slot5 = r_res_slot[SLOT_FIELD_W-1:0];
        end else begin : g_slot_ext
            assign slot5 = {{(SLOT_FIELD_W - SLOT_W){1'b0}}, r_res_slot};
        end
    endgenerate

    // Execute step: map updates and the result of the request.
    always_comb begin
        n_free       = r_free;
        n_used       = r_used;
        n_valid      = r_valid;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        ram_we       = 1'b0;
        if (i_cmd.exec) begin
            n_res_slot = '0;
            unique case (r_op)
                OP_ALLOC: begin
                    if (r_hit) begin
                        n_res_slot   = r_hit_slot;
                        n_res_status = ST_HELD;
                    end else if (!kind_ok || !r_low_nz) begin
                        n_res_status = ST_NONE;
                    end else if (!r_free_found) begin
                        n_res_status = ST_FULL;
                    end else begin
                        ram_we              = 1'b1;
                        n_valid[r_free_idx] = 1'b1;
                        for (int k = 0; k < KINDS; k++) begin
                            if (r_kind == KIND_W'(k)) begin
                                n_free[k] = r_free[k] & ~f_onehot(r_low_idx);
                                n_used[k] = r_used[k] | f_onehot(r_low_idx);
                            end
                        end
                        n_res_slot   = r_low_idx;
                        n_res_status = ST_NEW;
                    end
                end
                OP_RELEASE: begin
                    if (!r_hit) begin
                        n_res_status = ST_UNKNOWN;
                    end else begin
                        n_valid[r_hit_idx] = 1'b0;
                        // The slot goes back to the kind named by this request.
                        for (int k = 0; k < KINDS; k++) begin
                            if (r_kind == KIND_W'(k)) begin
                                n_free[k] = r_free[k] | f_onehot(r_hit_slot);
                                n_used[k] = r_used[k] & ~f_onehot(r_hit_slot);
                            end
                        end
                        n_res_slot   = r_hit_slot;
                        n_res_status = ST_FREED;
                    end
                end
                OP_RESET: begin
                    n_valid = '0;
                    for (int k = 0; k < KINDS; k++) begin
                        n_used[k] = '0;
                        n_free[k] = f_seed(r_limit[k]);
                    end
                    n_res_status = ST_RESET;
                end
                OP_QUERY: begin
                    n_res_status = ST_QUERY;
                end
                default: begin
                    n_res_status = ST_QUERY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KINDS; k++) begin
                r_limit[k] <= (k == KINDS - 1) ? LIMIT_RESET_ATOMIC : LIMIT_RESET_DEFAULT;
                r_free[k]  <= f_seed((k == KINDS - 1) ? LIMIT_RESET_ATOMIC
                                                      : LIMIT_RESET_DEFAULT);
                r_used[k]  <= '0;
            end
            r_valid   <= '0;
            r_rd_act  <= 1'b0;
            r_cmp_act <= 1'b0;
        end else begin
            r_free  <= n_free;
            r_used  <= n_used;
            r_valid <= n_valid;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LIMIT_STORAGE: r_limit[0] <= i_cfg_data;
                    CFG_LIMIT_UNIFORM: r_limit[1] <= i_cfg_data;
                    CFG_LIMIT_ARRAY:   r_limit[2] <= i_cfg_data;
                    CFG_LIMIT_ELEMENT: r_limit[3] <= i_cfg_data;
                    CFG_LIMIT_ATOMIC:  r_limit[4] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // The scan stops at the first hit, so the lowest matching entry wins.
            if (i_cmd.scan_start) begin
                r_rd_act  <= 1'b1;
                r_cmp_act <= 1'b0;
            end else begin
                r_cmp_act <= r_rd_act && !scan_done;
                if (scan_done || (r_rd_idx == LAST_IDX)) begin
                    r_rd_act <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_in_data.opcode;
            r_kind  <= i_in_data.buffer_kind;
            r_ident <= i_in_data.buffer_ident;
        end

        if (i_cmd.scan_start) begin
            r_rd_idx     <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (r_rd_act) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
            if (cmp_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_cmp_idx;
                r_hit_slot <= rd_slot;
            end
            if (r_cmp_act && !r_valid[r_cmp_idx] && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_cmp_idx;
            end
        end
        r_cmp_idx <= r_rd_idx;

        r_low_idx    <= n_low_idx;
        r_low_nz     <= |sel_free;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;

        // The used mask is taken after the execute step has updated the maps.
        if (i_cmd.out_load) begin
            r_out.slot      <= slot5;
            r_out.status    <= r_res_status;
            r_out.used_mask <= mask32;
        end
    end

    assign o_out_data = r_out;

endmodule

[rtl/binding_slot_allocator_unit.sv]
// Binding slot allocator: per-kind slot maps with an identifier-to-slot table.
// Allocate and release scan the identifier table, a memory read one entry per cycle that
// stops at the first hit; reset-bindings and query requests skip the scan. One request is in
// work at a time; a finished result waits in the output register while the next is accepted.
// Synchronous active-low reset clears all bindings and loads the default slot limits.
module binding_slot_allocator_unit #(
    parameter int SLOTS       = bsa_pkg::SLOTS_DEFAULT,
    parameter int MAP_ENTRIES = bsa_pkg::MAP_ENTRIES_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bsa_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bsa_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [bsa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bsa_pkg::LIMIT_W-1:0]   i_cfg_data
);
    import bsa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_in_data.opcode),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    bsa_dp #(
        .SLOTS       (SLOTS),
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );

endmodule
